@@ design/sprq_pkg.sv @@
// Shared types and constants for the sorted priority ready queue.
package sprq_pkg;

  // Queue geometry.
  localparam int QUEUE_DEPTH = 128;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Field widths.
  localparam int REQ_W = 2;
  localparam int ID_W = 7;
  localparam int PRI_W = 8;
  localparam int ST_W = 2;
  localparam int ECNT_W = 8;
  localparam int ENTRY_W = ID_W + PRI_W;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ = 2'd0,
    REQ_REM = 2'd1,
    REQ_POP = 2'd2,
    REQ_NOP = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_RSVD = 2'd3
  } st_t;

  // One stored queue entry.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // Read address source.
  typedef enum logic [1:0] {
    RD_DEC  = 2'd0,
    RD_INC  = 2'd1,
    RD_ZERO = 2'd2,
    RD_NONE = 2'd3
  } rd_sel_t;

  // Write data source.
  typedef enum logic {
    WR_REQ = 1'b0,
    WR_RD  = 1'b1
  } wr_sel_t;

  // Position register update.
  typedef enum logic [2:0] {
    POS_KEEP  = 3'd0,
    POS_COUNT = 3'd1,
    POS_ZERO  = 3'd2,
    POS_DEC   = 3'd3,
    POS_INC   = 3'd4
  } pos_sel_t;

  // Result payload source.
  typedef enum logic [1:0] {
    RES_KEEP = 2'd0,
    RES_REQ  = 2'd1,
    RES_RD   = 2'd2,
    RES_ZERO = 2'd3
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_req;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    pos_sel_t pos_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    res_sel_t res_sel;
    logic     st_load;
    st_t      st_val;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t req_type;
    logic full;
    logic cnt_zero;
    logic pos_zero;
    logic pri_le;
    logic id_match;
    logic shift_more;
    logic out_free;
  } stat_t;

endpackage

@@ design/sprq_dp.sv @@
// Datapath: entry memory, request latch, position and count registers, result register.
module sprq_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sprq_pkg::cmd_t                         cmd,
  output sprq_pkg::stat_t                        stat,
  input  logic [sprq_pkg::REQ_W-1:0]             in_req_type,
  input  logic [sprq_pkg::ID_W-1:0]              in_task_id,
  input  logic [sprq_pkg::PRI_W-1:0]             in_priority_req,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [sprq_pkg::ST_W-1:0]              out_status,
  output logic [sprq_pkg::ID_W-1:0]              out_task_id,
  output logic [sprq_pkg::PRI_W-1:0]             out_priority,
  output logic [sprq_pkg::ECNT_W-1:0]            out_entry_count
);

  // Entry memory and its registered read port.
  sprq_pkg::entry_t mem_r [sprq_pkg::QUEUE_DEPTH];
  sprq_pkg::entry_t rd_data_r;

  // Latched request.
  sprq_pkg::req_t             req_type_r;
  logic [sprq_pkg::ID_W-1:0]  req_id_r;
  logic [sprq_pkg::PRI_W-1:0] req_pri_r;

  // Walk position and occupancy.
  logic [sprq_pkg::CNT_W-1:0] pos_r;
  logic [sprq_pkg::CNT_W-1:0] pos_nxt;
  logic [sprq_pkg::CNT_W-1:0] cnt_r;
  logic [sprq_pkg::CNT_W:0]   pos_plus1;

  // Pending result and output register.
  sprq_pkg::st_t              st_r;
  sprq_pkg::entry_t           res_r;
  logic                       out_valid_r;
  sprq_pkg::st_t              out_st_r;
  sprq_pkg::entry_t           out_res_r;
  logic [sprq_pkg::ECNT_W-1:0] out_cnt_r;

  logic [sprq_pkg::IDX_W-1:0] rd_addr;
  logic [sprq_pkg::IDX_W-1:0] wr_addr;
  sprq_pkg::entry_t           wr_data;
  sprq_pkg::entry_t           req_entry;

  assign req_entry = '{id: req_id_r, pri: req_pri_r};
  assign pos_plus1 = {1'b0, pos_r} + {{sprq_pkg::CNT_W{1'b0}}, 1'b1};

  // Address and data selection for the memory.
  always_comb begin
    case (cmd.rd_sel)
      sprq_pkg::RD_DEC:  rd_addr = sprq_pkg::IDX_W'(pos_r - sprq_pkg::CNT_W'(1));
      sprq_pkg::RD_INC:  rd_addr = sprq_pkg::IDX_W'(pos_plus1);
      default:           rd_addr = '0;
    endcase
    wr_addr = sprq_pkg::IDX_W'(pos_r);
    wr_data = (cmd.wr_sel == sprq_pkg::WR_RD) ? rd_data_r : req_entry;
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Next position.
  always_comb begin
    case (cmd.pos_sel)
      sprq_pkg::POS_COUNT: pos_nxt = cnt_r;
      sprq_pkg::POS_ZERO:  pos_nxt = '0;
      sprq_pkg::POS_DEC:   pos_nxt = pos_r - sprq_pkg::CNT_W'(1);
      sprq_pkg::POS_INC:   pos_nxt = sprq_pkg::CNT_W'(pos_plus1);
      default:             pos_nxt = pos_r;
    endcase
  end

  // Request latch, position, pending result and output register payload (no reset needed).
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_r <= sprq_pkg::req_t'(in_req_type);
      req_id_r   <= in_task_id;
      req_pri_r  <= in_priority_req;
    end
    pos_r <= pos_nxt;
    if (cmd.st_load) begin
      st_r <= cmd.st_val;
    end
    case (cmd.res_sel)
      sprq_pkg::RES_REQ:  res_r <= req_entry;
      sprq_pkg::RES_RD:   res_r <= rd_data_r;
      sprq_pkg::RES_ZERO: res_r <= '0;
      default:            res_r <= res_r;
    endcase
    if (cmd.out_load) begin
      out_st_r  <= st_r;
      out_res_r <= res_r;
      out_cnt_r <= sprq_pkg::ECNT_W'(cnt_r);
    end
  end

  // Occupancy and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + sprq_pkg::CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - sprq_pkg::CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.req_type   = req_type_r;
    stat.full       = (cnt_r == sprq_pkg::CNT_W'(sprq_pkg::QUEUE_DEPTH));
    stat.cnt_zero   = (cnt_r == '0);
    stat.pos_zero   = (pos_r == '0);
    stat.pri_le     = (rd_data_r.pri <= req_pri_r);
    stat.id_match   = (rd_data_r.id == req_id_r);
    stat.shift_more = (pos_plus1 < {1'b0, cnt_r});
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_task_id     = out_res_r.id;
  assign out_priority    = out_res_r.pri;
  assign out_entry_count = out_cnt_r;

endmodule

@@ design/sprq_ctrl.sv @@
// Controller state machine that sequences enqueue, remove and pop over the entry memory.
module sprq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sprq_pkg::stat_t stat,
  output sprq_pkg::cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_ENQ_CHK  = 10'b00_0000_0100,
    S_ENQ_CMP  = 10'b00_0000_1000,
    S_REM_CHK  = 10'b00_0001_0000,
    S_REM_CMP  = 10'b00_0010_0000,
    S_POP_CAP  = 10'b00_0100_0000,
    S_SH_CHK   = 10'b00_1000_0000,
    S_SH_WR    = 10'b01_0000_0000,
    S_RESULT   = 10'b10_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.rd_sel   = sprq_pkg::RD_NONE;
    cmd.wr_sel   = sprq_pkg::WR_REQ;
    cmd.pos_sel  = sprq_pkg::POS_KEEP;
    cmd.res_sel  = sprq_pkg::RES_KEEP;
    cmd.st_val   = sprq_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.req_type)
          sprq_pkg::REQ_ENQ: begin
            if (stat.full) begin
              cmd.st_load = 1'b1;
              cmd.st_val  = sprq_pkg::ST_FULL;
              cmd.res_sel = sprq_pkg::RES_ZERO;
              state_nxt   = S_RESULT;
            end else begin
              cmd.pos_sel = sprq_pkg::POS_COUNT;
              state_nxt   = S_ENQ_CHK;
            end
          end
          sprq_pkg::REQ_REM: begin
            cmd.pos_sel = sprq_pkg::POS_COUNT;
            state_nxt   = S_REM_CHK;
          end
          sprq_pkg::REQ_POP: begin
            if (stat.cnt_zero) begin
              cmd.st_load = 1'b1;
              cmd.st_val  = sprq_pkg::ST_MISS;
              cmd.res_sel = sprq_pkg::RES_ZERO;
              state_nxt   = S_RESULT;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_sel  = sprq_pkg::RD_ZERO;
              cmd.pos_sel = sprq_pkg::POS_ZERO;
              state_nxt   = S_POP_CAP;
            end
          end
          default: begin
            cmd.st_load = 1'b1;
            cmd.st_val  = sprq_pkg::ST_MISS;
            cmd.res_sel = sprq_pkg::RES_ZERO;
            state_nxt   = S_RESULT;
          end
        endcase
      end
      // Walk up from the tail; place the new entry once a higher priority is found.
      S_ENQ_CHK: begin
        if (stat.pos_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = sprq_pkg::WR_REQ;
          cmd.cnt_inc = 1'b1;
          cmd.st_load = 1'b1;
          cmd.st_val  = sprq_pkg::ST_OK;
          cmd.res_sel = sprq_pkg::RES_REQ;
          state_nxt   = S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sprq_pkg::RD_DEC;
          state_nxt  = S_ENQ_CMP;
        end
      end
      S_ENQ_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.pri_le) begin
          cmd.wr_sel  = sprq_pkg::WR_RD;
          cmd.pos_sel = sprq_pkg::POS_DEC;
          state_nxt   = S_ENQ_CHK;
        end else begin
          cmd.wr_sel  = sprq_pkg::WR_REQ;
          cmd.cnt_inc = 1'b1;
          cmd.st_load = 1'b1;
          cmd.st_val  = sprq_pkg::ST_OK;
          cmd.res_sel = sprq_pkg::RES_REQ;
          state_nxt   = S_RESULT;
        end
      end
      // Search from the tail for the last matching id.
      S_REM_CHK: begin
        if (stat.pos_zero) begin
          cmd.st_load = 1'b1;
          cmd.st_val  = sprq_pkg::ST_MISS;
          cmd.res_sel = sprq_pkg::RES_ZERO;
          state_nxt   = S_RESULT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = sprq_pkg::RD_DEC;
          cmd.pos_sel = sprq_pkg::POS_DEC;
          state_nxt   = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        if (stat.id_match) begin
          cmd.st_load = 1'b1;
          cmd.st_val  = sprq_pkg::ST_OK;
          cmd.res_sel = sprq_pkg::RES_RD;
          state_nxt   = S_SH_CHK;
        end else begin
          state_nxt = S_REM_CHK;
        end
      end
      S_POP_CAP: begin
        cmd.st_load = 1'b1;
        cmd.st_val  = sprq_pkg::ST_OK;
        cmd.res_sel = sprq_pkg::RES_RD;
        state_nxt   = S_SH_CHK;
      end
      // Close the gap: move each later entry up by one slot.
      S_SH_CHK: begin
        if (stat.shift_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sprq_pkg::RD_INC;
          state_nxt  = S_SH_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_RESULT;
        end
      end
      S_SH_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = sprq_pkg::WR_RD;
        cmd.pos_sel = sprq_pkg::POS_INC;
        state_nxt   = S_SH_CHK;
      end
      // Hand the result to the output register once it is free.
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/sorted_priority_ready_queue.sv @@
// Top level of the sorted priority ready queue: stream ports around controller and datapath.
//
// A scheduler sends one request on the in_ channel: in_tuser carries the request
// type (enqueue, remove by id, pop highest priority), in_tdata the task id and
// priority. Each request returns exactly one result on the out_ channel: out_tuser
// is the status (ok, not found or empty, full and dropped), out_tdata the task id,
// priority and queue count after the request.
// Entries sit in one single-port-write memory sorted by descending priority, and
// requests are served one at a time; each entry move is a read followed by a write.
// Enqueue walks up from the tail, moving each entry of equal or lower priority down
// one slot, then writes the new entry; remove searches from the tail for the id and,
// if found, moves each entry behind it up one slot; pop reads the head and moves the
// rest up one slot; full, empty or unused code answer without touching memory.
// The next request can be accepted as soon as a result is loaded into the output
// register. A result waits in that register while out_tready is low; a new request
// may be accepted meanwhile, and its result waits until the register is taken.
// Reset (rst_n low at a clock edge) empties the queue and drops any pending result;
// no clearing pass.
module sorted_priority_ready_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [6:0] task_id, [14:7] priority_req, [15] zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [6:0] out_task_id, [14:7] out_priority, [22:15] entry_count
  output logic [1:0]  out_tuser   // [1:0] status
);

  sprq_pkg::cmd_t  cmd;
  sprq_pkg::stat_t stat;

  logic [sprq_pkg::ST_W-1:0]   res_status;
  logic [sprq_pkg::ID_W-1:0]   res_task_id;
  logic [sprq_pkg::PRI_W-1:0]  res_priority;
  logic [sprq_pkg::ECNT_W-1:0] res_count;

  sprq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sprq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_tuser),
    .in_task_id      (in_tdata[6:0]),
    .in_priority_req (in_tdata[14:7]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (res_status),
    .out_task_id     (res_task_id),
    .out_priority    (res_priority),
    .out_entry_count (res_count)
  );

  // Pack the result fields.
  assign out_tuser = res_status;
  assign out_tdata = {1'b0, res_count, res_priority, res_task_id};

endmodule
